@@ sv/mas_pkg.sv @@
// Shared types, constants and helpers for the matrix add/subtract/multiply unit.
package mas_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int ELEM_W      = 32;
  localparam int IDX_OUT_W   = 3;
  localparam int REG_DIM_W   = 4;
  localparam int OP_W        = 2;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 3;

  localparam logic [REG_DIM_W-1:0] DIM_RESET = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OPERATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 3'd4;

  // Operation codes as written to the operation register.
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    logic    valid;
    logic    first;
    logic    last;
    alu_op_t op;
  } alu_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } seq_state_t;

  // Zero counts as one, anything above the supported size saturates.
  function automatic logic [REG_DIM_W-1:0] clamp_dim(input logic [REG_DIM_W-1:0] d,
                                                     input int unsigned maxd);
    if (d == '0) begin
      return REG_DIM_W'(1);
    end else if (int'(d) > maxd) begin
      return REG_DIM_W'(maxd);
    end
    return d;
  endfunction

endpackage

@@ sv/matrix_add_sub_multiply_unit.sv @@
// Matrix add/subtract/multiply unit: loads A then B, then streams out C element by element.
// in_stall is high from the last element of B until the last element of C is taken. Each
// element of C passes through the shared arithmetic unit, once per inner index for
// multiply and once for add/subtract, and is held on the output until taken. A shape
// error emits zeros at one element per cycle while out_stall is low. A synchronous
// active-low reset resets the sequencer and configuration registers, not the memories.
module matrix_add_sub_multiply_unit
  import mas_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [ELEM_W-1:0]    in_element,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [ELEM_W-1:0]    out_result_value,
  output logic [IDX_OUT_W-1:0]        out_result_row,
  output logic [IDX_OUT_W-1:0]        out_result_col,
  output logic                        out_last_of_run,
  output logic                        out_shape_error
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W = $clog2(2 * DEPTH);
  localparam int TOT_W = POS_W + 1;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);

  logic [OP_W-1:0]      op_r;
  logic [REG_DIM_W-1:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;

  seq_state_t state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [IW-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [ELEM_W-1:0]    out_value_r, out_value_nxt;
  logic [IDX_OUT_W-1:0] out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic                 out_last_r, out_last_nxt, out_err_r, out_err_nxt;

  logic [DW-1:0]    ra, ca, rb, cb;
  logic [TOT_W-1:0] count_a, total, pos_ext, pos_inc, b_off;
  logic [TOT_W-1:0] addr_a_full, addr_b_full;
  logic [IW-1:0]    a_col, b_row, ni, nj;
  logic             is_mul, ok, in_a, in_acc, cfg_hit;
  logic             i_last, j_last, k_last, cur_last, next_last, start_last;
  alu_ctl_t         ctl;
  logic [ELEM_W-1:0] rd_a, rd_b, acc;
  logic              acc_done;

  assign ra = DW'(clamp_dim(rows_a_r, MAX_DIM));
  assign ca = DW'(clamp_dim(cols_a_r, MAX_DIM));
  assign rb = DW'(clamp_dim(rows_b_r, MAX_DIM));
  assign cb = DW'(clamp_dim(cols_b_r, MAX_DIM));

  assign is_mul = op_r[1];
  assign ok     = is_mul ? (rb == ca) : ((ra == rb) && (ca == cb));

  assign count_a = TOT_W'(ra) * TOT_W'(ca);
  assign total   = count_a + TOT_W'(rb) * TOT_W'(cb);
  assign pos_ext = TOT_W'(pos_r);
  assign pos_inc = pos_ext + TOT_W'(1);
  assign in_a    = pos_ext < count_a;
  assign b_off   = pos_ext - count_a;

  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign cfg_hit  = cfg_we && (cfg_index <= CFG_COLS_B);

  // Element addressing; multiply walks k along a row of A and down a column of B.
  assign a_col       = is_mul ? k_r : j_r;
  assign b_row       = is_mul ? k_r : i_r;
  assign addr_a_full = TOT_W'(i_r) * TOT_W'(ca) + TOT_W'(a_col);
  assign addr_b_full = TOT_W'(b_row) * TOT_W'(cb) + TOT_W'(j_r);

  assign i_last     = (DW'(i_r) == ra - DW'(1));
  assign j_last     = (DW'(j_r) == cb - DW'(1));
  assign k_last     = (DW'(k_r) == ca - DW'(1));
  assign cur_last   = i_last && j_last;
  assign start_last = (ra == DW'(1)) && (cb == DW'(1));
  assign nj         = j_last ? '0 : j_r + IW'(1);
  assign ni         = j_last ? i_r + IW'(1) : i_r;
  assign next_last  = (DW'(ni) == ra - DW'(1)) && (DW'(nj) == cb - DW'(1));

  mas_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_a (
    .clk   (clk),
    .we    (in_acc && in_a),
    .waddr (pos_r[AW-1:0]),
    .wdata (in_element),
    .raddr (addr_a_full[AW-1:0]),
    .rdata (rd_a)
  );

  mas_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_b (
    .clk   (clk),
    .we    (in_acc && !in_a),
    .waddr (b_off[AW-1:0]),
    .wdata (in_element),
    .raddr (addr_b_full[AW-1:0]),
    .rdata (rd_b)
  );

  mas_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .x     (rd_a),
    .y     (rd_b),
    .acc   (acc),
    .done  (acc_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r     <= OP_ADD;
      rows_a_r <= DIM_RESET;
      cols_a_r <= DIM_RESET;
      rows_b_r <= DIM_RESET;
      cols_b_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OPERATION: op_r     <= cfg_data[OP_W-1:0];
        CFG_ROWS_A:    rows_a_r <= cfg_data;
        CFG_COLS_A:    cols_a_r <= cfg_data;
        CFG_ROWS_B:    rows_b_r <= cfg_data;
        CFG_COLS_B:    cols_b_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      pos_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_last_r  <= out_last_nxt;
    out_err_r   <= out_err_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    ctl.valid     = 1'b0;
    ctl.first     = (k_r == '0);
    ctl.last      = !is_mul || k_last;
    ctl.op        = is_mul ? ALU_MUL : ((op_r == OP_SUB) ? ALU_SUB : ALU_ADD);

    case (state_r)
      ST_LOAD: begin
        if (cfg_hit) begin
          pos_nxt = '0;
        end
        if (in_acc) begin
          i_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
          if (pos_inc == total) begin
            pos_nxt = '0;
            if (ok) begin
              state_nxt = ST_RUN;
            end else begin
              // Mismatched shapes: emit the zero matrix straight away.
              state_nxt     = ST_OUT;
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              out_row_nxt   = '0;
              out_col_nxt   = '0;
              out_last_nxt  = start_last;
              out_err_nxt   = 1'b1;
            end
          end else begin
            pos_nxt = pos_inc[POS_W-1:0];
          end
        end
      end
      ST_RUN: begin
        ctl.valid = 1'b1;
        if (ctl.last) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      ST_DRAIN: begin
        if (acc_done) begin
          state_nxt     = ST_OUT;
          out_valid_nxt = 1'b1;
          out_value_nxt = acc;
          out_row_nxt   = IDX_OUT_W'(i_r);
          out_col_nxt   = IDX_OUT_W'(j_r);
          out_last_nxt  = cur_last;
          out_err_nxt   = 1'b0;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = ST_LOAD;
          end else begin
            i_nxt = ni;
            j_nxt = nj;
            k_nxt = '0;
            if (ok) begin
              state_nxt = ST_RUN;
            end else begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              out_row_nxt   = IDX_OUT_W'(ni);
              out_col_nxt   = IDX_OUT_W'(nj);
              out_last_nxt  = next_last;
              out_err_nxt   = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_result_row   = out_row_r;
  assign out_result_col   = out_col_r;
  assign out_last_of_run  = out_last_r;
  assign out_shape_error  = out_err_r;

endmodule

@@ sv/mas_ram.sv @@
// Single write port, single registered read port element memory.
module mas_ram
  import mas_pkg::*;
#(
  parameter int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [ELEM_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [ELEM_W-1:0] rdata
);

  logic [ELEM_W-1:0] mem [0:DEPTH-1];
  logic [ELEM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/mas_alu.sv @@
// Shared arithmetic unit: one add/subtract/multiply stage followed by an accumulator.
module mas_alu
  import mas_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  alu_ctl_t          ctl,
  input  logic [ELEM_W-1:0] x,
  input  logic [ELEM_W-1:0] y,
  output logic [ELEM_W-1:0] acc,
  output logic              done
);

  alu_ctl_t          ctl_d1_r;
  alu_ctl_t          ctl_d2_r;
  logic [ELEM_W-1:0] res_nxt;
  logic [ELEM_W-1:0] res_r;
  logic [ELEM_W-1:0] acc_r;
  logic              done_r;
  logic [ELEM_W-1:0] prod;

  // Operands arrive in the cycle after the control word, as the memories register their reads.
  assign prod = x * y;

  always_comb begin
    case (ctl_d1_r.op)
      ALU_MUL: res_nxt = prod;
      ALU_SUB: res_nxt = x - y;
      ALU_ADD: res_nxt = x + y;
      default: res_nxt = x + y;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d1_r <= '0;
      ctl_d2_r <= '0;
      done_r   <= 1'b0;
    end else begin
      ctl_d1_r <= ctl;
      ctl_d2_r <= ctl_d1_r;
      done_r   <= ctl_d2_r.valid && ctl_d2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (ctl_d2_r.valid) begin
      acc_r <= ctl_d2_r.first ? res_r : acc_r + res_r;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

@@ tb/tb_matrix_add_sub_multiply_unit.sv @@
// Self-checking testbench for the matrix add/subtract/multiply unit.
module tb_matrix_add_sub_multiply_unit
  import mas_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT      = 34;
  localparam int RANDOM_ITEMS  = 96;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 4000;

  // Operation codes that the package does not name.
  localparam logic [CFG_W-1:0] OP_MUL_ALT       = {2'b00, 2'b11};
  localparam logic [CFG_W-1:0] OP_MUL_HIGH_BITS = {2'b11, OP_MUL};
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_COLS_B + 3'd1;

  typedef struct {
    logic [ELEM_W-1:0]    value;
    logic [IDX_OUT_W-1:0] row;
    logic [IDX_OUT_W-1:0] col;
    logic                 last;
    logic                 shape_err;
  } c_elem_t;

  class matrix_result_checker;
    logic [ELEM_W-1:0] a_mem [MAX_DIM_DEF*MAX_DIM_DEF];
    logic [ELEM_W-1:0] b_mem [MAX_DIM_DEF*MAX_DIM_DEF];
    int unsigned load_pos;
    logic [OP_W-1:0] op_reg;
    logic [REG_DIM_W-1:0] ra_reg, ca_reg, rb_reg, cb_reg;
    c_elem_t expected_c[$];
    int unsigned mismatches, results_seen, shape_errs, jobs_done, elements_taken;

    function new();
      load_pos = 0;
      op_reg = OP_ADD;
      ra_reg = DIM_RESET;
      ca_reg = DIM_RESET;
      rb_reg = DIM_RESET;
      cb_reg = DIM_RESET;
    endfunction

    function int unsigned eff_dim(logic [REG_DIM_W-1:0] d);
      if (d == '0) return 1;
      if (d > REG_DIM_W'(MAX_DIM_DEF)) return MAX_DIM_DEF;
      return 32'(d);
    endfunction

    function int unsigned job_length();
      return eff_dim(ra_reg) * eff_dim(ca_reg) + eff_dim(rb_reg) * eff_dim(cb_reg);
    endfunction

    function int unsigned pending();
      return expected_c.size();
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_OPERATION: op_reg = data[OP_W-1:0];
        CFG_ROWS_A:    ra_reg = data;
        CFG_COLS_A:    ca_reg = data;
        CFG_ROWS_B:    rb_reg = data;
        CFG_COLS_B:    cb_reg = data;
        default:       return;
      endcase
      // Any write to a real register throws away a half-loaded job.
      load_pos = 0;
    endfunction

    function void take_element(logic [ELEM_W-1:0] e);
      int unsigned ra, ca, rb, cb, count_a;
      logic [ELEM_W-1:0] acc;
      bit is_mul, fits;
      c_elem_t r;
      ra = eff_dim(ra_reg);
      ca = eff_dim(ca_reg);
      rb = eff_dim(rb_reg);
      cb = eff_dim(cb_reg);
      count_a = ra * ca;
      elements_taken++;
      if (load_pos < count_a) a_mem[load_pos] = e;
      else b_mem[load_pos - count_a] = e;
      if (load_pos + 1 < job_length()) begin
        load_pos++;
        return;
      end
      load_pos = 0;
      jobs_done++;
      // Operation codes two and three both multiply.
      is_mul = op_reg[1];
      fits = is_mul ? (rb == ca) : (ra == rb && ca == cb);
      for (int i = 0; i < ra; i++) begin
        for (int j = 0; j < cb; j++) begin
          acc = '0;
          if (fits) begin
            if (is_mul) begin
              for (int k = 0; k < ca; k++) acc = acc + a_mem[i*ca + k] * b_mem[k*cb + j];
            end else if (op_reg == OP_SUB) begin
              acc = a_mem[i*ca + j] - b_mem[i*cb + j];
            end else begin
              acc = a_mem[i*ca + j] + b_mem[i*cb + j];
            end
          end
          r.value = acc;
          r.row = i[IDX_OUT_W-1:0];
          r.col = j[IDX_OUT_W-1:0];
          r.last = (i + 1 == ra) && (j + 1 == cb);
          r.shape_err = !fits;
          expected_c.push_back(r);
        end
      end
    endfunction

    function void check_result(logic [ELEM_W-1:0] value, logic [IDX_OUT_W-1:0] row,
                               logic [IDX_OUT_W-1:0] col, logic last, logic shape_err);
      c_elem_t want;
      results_seen++;
      if (shape_err) shape_errs++;
      if (expected_c.size() == 0) begin
        $error("unexpected result: value %0d row %0d col %0d", $signed(value), row, col);
        mismatches++;
        return;
      end
      want = expected_c.pop_front();
      if (value !== want.value) begin
        $error("result_value: expected %0d, got %0d", $signed(want.value), $signed(value));
        mismatches++;
      end
      if (row !== want.row) begin
        $error("result_row: expected %0d, got %0d", want.row, row);
        mismatches++;
      end
      if (col !== want.col) begin
        $error("result_col: expected %0d, got %0d", want.col, col);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0b, got %0b", want.last, last);
        mismatches++;
      end
      if (shape_err !== want.shape_err) begin
        $error("shape_error: expected %0b, got %0b", want.shape_err, shape_err);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [ELEM_W-1:0] in_element = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [ELEM_W-1:0] out_result_value;
  logic [IDX_OUT_W-1:0]     out_result_row;
  logic [IDX_OUT_W-1:0]     out_result_col;
  logic                     out_last_of_run;
  logic                     out_shape_error;

  matrix_result_checker sb = new();
  int in_idle_pct = IDLE_PCT;
  int out_idle_pct = IDLE_PCT;
  int unsigned elements_sent = 0;
  int unsigned quiet_cycles = 0;

  matrix_add_sub_multiply_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element       (in_element),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_result_row   (out_result_row),
    .out_result_col   (out_result_col),
    .out_last_of_run  (out_last_of_run),
    .out_shape_error  (out_shape_error)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: check every transaction taken, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_result_value, out_result_row, out_result_col,
                      out_last_of_run, out_shape_error);
    end
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_element(input logic [ELEM_W-1:0] v);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_element(v);
    elements_sent++;
  endtask

  // Drops valid, waits for every outstanding result, then lets the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.apply_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] op_code, input logic [CFG_W-1:0] ra,
                           input logic [CFG_W-1:0] ca, input logic [CFG_W-1:0] rb,
                           input logic [CFG_W-1:0] cb);
    wait_drained();
    write_reg(CFG_OPERATION, op_code);
    write_reg(CFG_ROWS_A, ra);
    write_reg(CFG_COLS_A, ca);
    write_reg(CFG_ROWS_B, rb);
    write_reg(CFG_COLS_B, cb);
  endtask

  function automatic logic [ELEM_W-1:0] pick_element();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) begin
      case ($urandom_range(3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    if (r < 35) return ELEM_W'($signed($urandom_range(16)) - 8);
    return $urandom;
  endfunction

  // Mostly small sizes keep jobs short; zero and oversized values appear now and then.
  function automatic logic [CFG_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return CFG_W'($urandom_range(15, 9));
    if (r < 20) return CFG_W'($urandom_range(8, 4));
    return CFG_W'($urandom_range(3, 1));
  endfunction

  task automatic random_job(input bit wide_inner);
    logic [CFG_W-1:0] op_code, ra, ca, rb, cb;
    int unsigned n;
    case ($urandom_range(3))
      0: op_code = CFG_W'(OP_ADD);
      1: op_code = CFG_W'(OP_SUB);
      2: op_code = CFG_W'(OP_MUL);
      default: op_code = OP_MUL_ALT;
    endcase
    ra = pick_dim();
    ca = pick_dim();
    rb = pick_dim();
    cb = pick_dim();
    if (wide_inner) begin
      op_code = CFG_W'(OP_MUL);
      ra = 4'd1;
      ca = CFG_W'(MAX_DIM_DEF);
      rb = CFG_W'(MAX_DIM_DEF);
      cb = 4'd2;
    end else if ($urandom_range(99) < 85) begin
      if (op_code[1]) begin
        rb = ca;
      end else begin
        rb = ra;
        cb = ca;
      end
    end
    configure(op_code, ra, ca, rb, cb);
    if ($urandom_range(99) < 15) begin
      write_reg(CFG_UNUSED_LO + CFG_IDX_W'($urandom_range(2)), CFG_W'($urandom));
    end
    n = sb.job_length();
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(n - 1)) send_element(pick_element());
      wait_drained();
      write_reg(CFG_OPERATION, op_code);
    end
    repeat (n) send_element(pick_element());
  endtask

  initial begin
    int unsigned random_start;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Wraparound on add and subtract at the signed limits.
    configure(CFG_W'(OP_ADD), 4'd1, 4'd1, 4'd1, 4'd1);
    send_element(32'h7FFF_FFFF);
    send_element(32'h0000_0001);
    configure(CFG_W'(OP_SUB), 4'd1, 4'd1, 4'd1, 4'd1);
    send_element(32'h8000_0000);
    // A write to an index past the register list must not disturb the load.
    wait_drained();
    write_reg(CFG_UNUSED_LO, '1);
    send_element(32'h0000_0001);

    // Upper data bits of the operation are dropped; a register write abandons the load.
    configure(OP_MUL_HIGH_BITS, 4'd1, 4'd1, 4'd1, 4'd1);
    send_element(32'hFFFF_FFFF);
    wait_drained();
    write_reg(CFG_OPERATION, CFG_W'(OP_MUL));
    send_element(32'hFFFF_FFFF);
    send_element(32'h8000_0000);

    // Operation three multiplies; a zero dimension counts as one; inner sizes differ.
    configure(OP_MUL_ALT, 4'd0, 4'd2, 4'd1, 4'd1);
    send_element(32'h0000_0001);
    send_element(32'hFFFF_FFFF);
    send_element(32'h7FFF_FFFF);

    // Oversized row count saturates: an outer product fills the whole 8x8 result.
    configure(CFG_W'(OP_MUL), 4'd15, 4'd1, 4'd1, 4'd8);
    repeat (sb.job_length()) send_element(pick_element());

    random_start = elements_sent;
    random_job(1'b1);
    while (elements_sent - random_start < RANDOM_ITEMS) begin
      if (elements_sent - random_start >= 40 && elements_sent - random_start < 75) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
      end
      random_job(1'b0);
    end

    wait_drained();
    $display("Loaded %0d elements over %0d jobs; checked %0d result elements, %0d of them",
             sb.elements_taken, sb.jobs_done, sb.results_seen, sb.shape_errs);
    $display("with a shape error, across add, subtract and multiply at sizes from 1 to 8.");
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
